@@ rtl/core/mspr_pkg.sv @@
package mspr_pkg;

	localparam int MAX_DIM     = 8;
	localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int DATA_W      = 32;
	localparam int DIM_W       = 4;
	localparam int IDX_W       = 3;
	localparam int CNT_W       = 7;

	localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

	// one input word: matching elements of a, b and c
	typedef struct packed {
		logic signed [DATA_W-1:0] a_elem;
		logic signed [DATA_W-1:0] b_elem;
		logic signed [DATA_W-1:0] c_elem;
	} in_word_t;

	// one result word
	typedef struct packed {
		logic [IDX_W-1:0]         row_index;
		logic [IDX_W-1:0]         col_index;
		logic signed [DATA_W-1:0] sum_elem;
		logic signed [DATA_W-1:0] product_elem;
		logic signed [DATA_W-1:0] running_total;
		logic                     last_result;
	} out_word_t;

	// controller to datapath commands
	typedef struct packed {
		logic              wr_en;
		logic [ADDR_W-1:0] wr_pos;
		logic              rd_en;
		logic [ADDR_W-1:0] c_addr;
		logic [ADDR_W-1:0] d_addr;
		logic              first;
		logic              last;
		logic              capture;
		logic              push;
		logic              clr_total;
		logic [IDX_W-1:0]  row;
		logic [IDX_W-1:0]  col;
		logic              last_res;
	} mspr_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic acc_done;
		logic out_free;
	} mspr_sts_t;

	// side length in use: zero reads as one, large values clamp
	function automatic logic [DIM_W-1:0] side_of(input logic [DIM_W-1:0] dim);
		logic [DIM_W-1:0] s;
		s = dim;
		if (s == '0)
			s = DIM_W'(1);
		if (s > DIM_W'(MAX_DIM))
			s = DIM_W'(MAX_DIM);
		return s;
	endfunction

endpackage

@@ rtl/core/mspr_ram.sv @@
module mspr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_addr] <= wr_data;
		if (rd_en)
			rd_data <= mem_q[rd_addr];
	end

endmodule

@@ rtl/core/mspr_dp.sv @@
module mspr_dp
	import mspr_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  in_word_t  in_word,
	input  mspr_cmd_t cmd,
	output mspr_sts_t sts,
	output logic      out_valid,
	input  logic      out_stall,
	output out_word_t out_word
);

	logic [DATA_W-1:0] sum_wr;
	logic [DATA_W-1:0] c_rd;
	logic [DATA_W-1:0] d_rd;

	logic              valid_s1, first_s1, last_s1, cap_s1;
	logic              valid_s2, first_s2, last_s2, cap_s2;
	logic [DATA_W-1:0] prod_s2;
	logic [DATA_W-1:0] dval_s2;

	logic [DATA_W-1:0] acc_q;
	logic [DATA_W-1:0] sum_q;
	logic [DATA_W-1:0] total_q;
	logic [DATA_W-1:0] total_next;
	logic              done_q;
	logic              out_valid_q;
	out_word_t         out_q;

	assign sum_wr = DATA_W'(in_word.a_elem + in_word.b_elem);

	// d = a + b store
	mspr_ram #(.WIDTH(DATA_W), .DEPTH(STORE_DEPTH)) u_sum_ram (
		.clk     (clk),
		.wr_en   (cmd.wr_en),
		.wr_addr (cmd.wr_pos),
		.wr_data (sum_wr),
		.rd_en   (cmd.rd_en),
		.rd_addr (cmd.d_addr),
		.rd_data (d_rd)
	);

	// c store
	mspr_ram #(.WIDTH(DATA_W), .DEPTH(STORE_DEPTH)) u_c_ram (
		.clk     (clk),
		.wr_en   (cmd.wr_en),
		.wr_addr (cmd.wr_pos),
		.wr_data (DATA_W'(in_word.c_elem)),
		.rd_en   (cmd.rd_en),
		.rd_addr (cmd.c_addr),
		.rd_data (c_rd)
	);

	// tags follow the ram read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= cmd.rd_en;
			valid_s2 <= valid_s1;
		end
	end

	// multiply stage, low word only
	always_ff @(posedge clk) begin
		first_s1 <= cmd.first;
		last_s1  <= cmd.last;
		cap_s1   <= cmd.capture;
		first_s2 <= first_s1;
		last_s2  <= last_s1;
		cap_s2   <= cap_s1;
		dval_s2  <= d_rd;
		prod_s2  <= c_rd * d_rd;
	end

	// accumulate stage
	always_ff @(posedge clk) begin
		if (valid_s2) begin
			acc_q <= first_s2 ? prod_s2 : acc_q + prod_s2;
			if (cap_s2)
				sum_q <= dval_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_q <= 1'b0;
		else if (valid_s2 && last_s2)
			done_q <= 1'b1;
		else if (cmd.push)
			done_q <= 1'b0;
	end

	assign total_next = total_q + acc_q;

	// grand total
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			total_q <= '0;
		else if (cmd.clr_total)
			total_q <= '0;
		else if (cmd.push)
			total_q <= total_next;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.push)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			out_q.row_index     <= cmd.row;
			out_q.col_index     <= cmd.col;
			out_q.sum_elem      <= sum_q;
			out_q.product_elem  <= acc_q;
			out_q.running_total <= total_next;
			out_q.last_result   <= cmd.last_res;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_word      = out_q;
	assign sts.acc_done  = done_q;
	assign sts.out_free  = !out_valid_q || !out_stall;

endmodule

@@ rtl/core/mspr_ctrl.sv @@
module mspr_ctrl
	import mspr_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic             dim_wr_en,
	input  logic [DIM_W-1:0] dim_wr_data,
	input  mspr_sts_t        sts,
	output mspr_cmd_t        cmd
);

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_ISSUE,
		ST_WAIT
	} state_t;

	state_t           state_q;
	logic [DIM_W-1:0] dim_q;
	logic [CNT_W-1:0] load_cnt_q;
	logic [IDX_W-1:0] i_q, j_q, z_q;

	logic [DIM_W-1:0] side;
	logic [IDX_W-1:0] side_m1;
	logic [CNT_W-1:0] cells;
	logic [CNT_W-1:0] load_next;
	logic             accept;
	logic             frame_full;
	logic             z_last;
	logic             j_last;
	logic             i_last;
	logic             push;
	logic [CNT_W-1:0] c_base;
	logic [CNT_W-1:0] d_base;

	assign side      = side_of(dim_q);
	assign side_m1   = IDX_W'(side - DIM_W'(1));
	assign cells     = CNT_W'(side) * CNT_W'(side);
	assign load_next = load_cnt_q + CNT_W'(1);

	assign in_stall   = (state_q != ST_LOAD);
	assign accept     = in_valid && !in_stall;
	assign frame_full = (load_next >= cells);

	assign z_last = (z_q == side_m1);
	assign j_last = (j_q == side_m1);
	assign i_last = (i_q == side_m1);
	assign push   = (state_q == ST_WAIT) && sts.acc_done && sts.out_free;

	// row bases for c[i][z] and d[z][j]
	assign c_base = CNT_W'(i_q) * CNT_W'(side);
	assign d_base = CNT_W'(z_q) * CNT_W'(side);

	// commands to the datapath
	always_comb begin
		cmd.wr_en     = accept;
		cmd.wr_pos    = load_cnt_q[ADDR_W-1:0];
		cmd.rd_en     = (state_q == ST_ISSUE);
		cmd.c_addr    = c_base[ADDR_W-1:0] + ADDR_W'(z_q);
		cmd.d_addr    = d_base[ADDR_W-1:0] + ADDR_W'(j_q);
		cmd.first     = (z_q == '0);
		cmd.last      = z_last;
		cmd.capture   = (z_q == i_q);
		cmd.push      = push;
		cmd.clr_total = dim_wr_en || (accept && frame_full);
		cmd.row       = i_q;
		cmd.col       = j_q;
		cmd.last_res  = i_last && j_last;
	end

	// sequencer: load, then one issue and wait pass per result element
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_LOAD;
			dim_q      <= DIM_RESET;
			load_cnt_q <= '0;
			i_q        <= '0;
			j_q        <= '0;
			z_q        <= '0;
		end else begin
			if (dim_wr_en) begin
				dim_q      <= dim_wr_data;
				load_cnt_q <= '0;
			end
			case (state_q)
				ST_LOAD: begin
					if (accept && !dim_wr_en) begin
						if (frame_full) begin
							load_cnt_q <= '0;
							i_q        <= '0;
							j_q        <= '0;
							z_q        <= '0;
							state_q    <= ST_ISSUE;
						end else begin
							load_cnt_q <= load_next;
						end
					end
				end
				ST_ISSUE: begin
					if (z_last) begin
						z_q     <= '0;
						state_q <= ST_WAIT;
					end else begin
						z_q <= z_q + IDX_W'(1);
					end
				end
				ST_WAIT: begin
					if (push) begin
						if (j_last) begin
							j_q <= '0;
							i_q <= i_q + IDX_W'(1);
						end else begin
							j_q <= j_q + IDX_W'(1);
						end
						state_q <= (i_last && j_last) ? ST_LOAD : ST_ISSUE;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

endmodule

@@ rtl/core/matrix_sum_product_reduce_top.sv @@
// loading takes one input word per cycle; the word that completes a frame of dim*dim
// starts the product pass, during which input is stalled
// each result element runs on the single shared multiply-accumulate unit
// (dim ram reads, then multiply and accumulate stages); the next element's reads
// start only after the previous result is pushed to the output register
// reset clears control, dim (to 8), the load count and the total; stores hold garbage
module matrix_sum_product_reduce_top
	import mspr_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  in_word_t         in_word,
	output logic             out_valid,
	input  logic             out_stall,
	output out_word_t        out_word,
	input  logic             dim_wr_en,
	input  logic [DIM_W-1:0] dim_wr_data
);

	mspr_cmd_t cmd;
	mspr_sts_t sts;

	// sequencer
	mspr_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.dim_wr_en   (dim_wr_en),
		.dim_wr_data (dim_wr_data),
		.sts         (sts),
		.cmd         (cmd)
	);

	// stores, multiply-accumulate and output word
	mspr_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_word   (in_word),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word)
	);

endmodule
